// ===== rtl/core/mcc_pkg.sv =====
// Shared types, state encodings and modular arithmetic helpers for the column checker.
package mcc_pkg;

    localparam int unsigned MOD_W = 31;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned COL_W = 32;
    localparam int unsigned CNT_W = 5;

    // Last count of each serial phase: one coefficient bit or one magnitude bit per cycle.
    localparam logic [CNT_W-1:0] REDUCE_LAST = CNT_W'(MOD_W - 1);
    localparam logic [CNT_W-1:0] MULT_LAST   = CNT_W'(VAL_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_FINISH
    } mcc_state_t;

    typedef enum logic [1:0] {
        EN_IDLE,
        EN_REDUCE,
        EN_MULT,
        EN_FIX
    } eng_state_t;

    typedef struct packed {
        logic               start;
        logic [VAL_W-1:0]   magnitude;
        logic               negative;
        logic [MOD_W-1:0]   coefficient;
        logic [MOD_W-1:0]   accumulator;
        logic [MOD_W-1:0]   modulus;
    } eng_req_t;

    typedef struct packed {
        logic               done;
        logic [MOD_W-1:0]   product;
        logic [MOD_W-1:0]   acc_residue;
    } eng_sts_t;

    // Shift one bit into a residue: (2r + b) mod m, with r below m.
    function automatic logic [MOD_W-1:0] mod_shift_in(
        input logic [MOD_W-1:0] r,
        input logic             b,
        input logic [MOD_W-1:0] m
    );
        logic [MOD_W:0] t;
        t = {r, b};
        if (t >= {1'b0, m})
        begin
            t = t - {1'b0, m};
        end
        return t[MOD_W-1:0];
    endfunction

    // (a + b) mod m, with a and b below m.
    function automatic logic [MOD_W-1:0] mod_add(
        input logic [MOD_W-1:0] a,
        input logic [MOD_W-1:0] b,
        input logic [MOD_W-1:0] m
    );
        logic [MOD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[MOD_W-1:0];
    endfunction

endpackage

// ===== rtl/core/mcc_channels.sv =====
// Channel interfaces for term requests, result requests and the prime register write.
interface mcc_term_if;
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       matrix_value;
    logic        [30:0]       coefficient;
    logic        [30:0]       target_value;
    logic                     last_term;

    modport source (output valid, matrix_value, coefficient, target_value, last_term,
                    input ready);
    modport sink   (input valid, matrix_value, coefficient, target_value, last_term,
                    output ready);
endinterface

interface mcc_result_if;
    logic                     valid;
    logic                     ready;
    logic        [31:0]       column_index;
    logic                     mismatch;

    modport source (output valid, column_index, mismatch, input ready);
    modport sink   (input valid, column_index, mismatch, output ready);
endinterface

interface mcc_cfg_if;
    logic                     valid;
    logic                     ready;
    logic        [30:0]       prime;

    modport source (output valid, prime, input ready);
    modport sink   (input valid, prime, output ready);
endinterface

// ===== rtl/core/mcc_term_engine.sv =====
// Bit-serial engine: reduces coefficient and accumulator, then forms the signed term mod m.
module mcc_term_engine
    import mcc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  eng_req_t req,
    output eng_sts_t sts
);

    eng_state_t       state_reg, state_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [VAL_W-1:0] mag_reg, mag_next;
    logic             neg_reg, neg_next;
    logic [MOD_W-1:0] coef_reg, coef_next;
    logic [MOD_W-1:0] acc_reg, acc_next;
    logic [MOD_W-1:0] mod_reg, mod_next;
    logic [MOD_W-1:0] rc_reg, rc_next;
    logic [MOD_W-1:0] ra_reg, ra_next;
    logic [MOD_W-1:0] prod_reg, prod_next;
    logic [MOD_W-1:0] dbl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EN_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        coef_reg <= coef_next;
        acc_reg  <= acc_next;
        mod_reg  <= mod_next;
        rc_reg   <= rc_next;
        ra_reg   <= ra_next;
        prod_reg <= prod_next;
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        coef_next  = coef_reg;
        acc_next   = acc_reg;
        mod_next   = mod_reg;
        rc_next    = rc_reg;
        ra_next    = ra_reg;
        prod_next  = prod_reg;
        dbl        = mod_add(prod_reg, prod_reg, mod_reg);

        case (state_reg)
            EN_IDLE:
            begin
                if (req.start)
                begin
                    mag_next   = req.magnitude;
                    neg_next   = req.negative;
                    coef_next  = req.coefficient;
                    acc_next   = req.accumulator;
                    mod_next   = req.modulus;
                    rc_next    = '0;
                    ra_next    = '0;
                    cnt_next   = '0;
                    state_next = EN_REDUCE;
                end
            end
            EN_REDUCE:
            begin
                // Coefficient and accumulator are reduced side by side, MSB first.
                rc_next   = mod_shift_in(rc_reg, coef_reg[MOD_W-1], mod_reg);
                ra_next   = mod_shift_in(ra_reg, acc_reg[MOD_W-1], mod_reg);
                coef_next = {coef_reg[MOD_W-2:0], 1'b0};
                acc_next  = {acc_reg[MOD_W-2:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == REDUCE_LAST)
                begin
                    cnt_next   = '0;
                    prod_next  = '0;
                    state_next = EN_MULT;
                end
            end
            EN_MULT:
            begin
                // Horner over the magnitude bits: p = 2p + bit * c, all mod m.
                prod_next = mag_reg[VAL_W-1] ? mod_add(dbl, rc_reg, mod_reg) : dbl;
                mag_next  = {mag_reg[VAL_W-2:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == MULT_LAST)
                begin
                    state_next = EN_FIX;
                end
            end
            EN_FIX:
            begin
                // A negative entry turns a nonzero product into its complement.
                if (neg_reg && (prod_reg != '0))
                begin
                    prod_next = mod_reg - prod_reg;
                end
                done_next  = 1'b1;
                state_next = EN_IDLE;
            end
            default:
            begin
                state_next = EN_IDLE;
            end
        endcase
    end

    assign sts.done        = done_reg;
    assign sts.product     = prod_reg;
    assign sts.acc_residue = ra_reg;

endmodule

// ===== rtl/core/modular_column_check.sv =====
// Top level of the modular column checker: handshakes, accumulator, column counter.
// A term is accepted, then its coefficient and accumulator are reduced one bit each, it is multiplied
// by one entry bit each, and fix, add and finish follow.
// A result enters the output register once its last term is through the engine; the next term
// can be accepted in the cycle the result appears, unless an earlier result still waits.
// Reset (rst_n, asynchronous, active low) clears accumulator and counter; prime 2147483647.
module modular_column_check
    import mcc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mcc_cfg_if.sink      cfg,
    mcc_term_if.sink     term_in,
    mcc_result_if.source result_out
);

    mcc_state_t       state_reg, state_next;
    logic [MOD_W-1:0] prime_reg;
    logic [MOD_W-1:0] acc_reg, acc_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             out_valid_reg, out_valid_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic             out_mis_reg, out_mis_next;
    logic [MOD_W-1:0] mod_reg, mod_next;
    logic [MOD_W-1:0] target_reg, target_next;
    logic             last_reg, last_next;
    logic [MOD_W-1:0] sum_reg, sum_next;

    logic             accept;
    logic             out_free;
    eng_req_t         eng_req;
    eng_sts_t         eng_sts;

    assign cfg.ready         = 1'b1;
    assign term_in.ready     = (state_reg == ST_IDLE);
    assign accept            = term_in.valid && term_in.ready;
    assign out_free          = !out_valid_reg || result_out.ready;

    assign result_out.valid        = out_valid_reg;
    assign result_out.column_index = out_col_reg;
    assign result_out.mismatch     = out_mis_reg;

    always_comb
    begin
        eng_req.start       = accept;
        eng_req.negative    = term_in.matrix_value[VAL_W-1];
        eng_req.magnitude   = term_in.matrix_value[VAL_W-1]
                            ? (~term_in.matrix_value + 1'b1)
                            : term_in.matrix_value;
        eng_req.coefficient = term_in.coefficient;
        eng_req.accumulator = acc_reg;
        // Primes of zero and one behave as modulus one.
        eng_req.modulus     = (prime_reg < MOD_W'(2)) ? MOD_W'(1) : prime_reg;
    end

    mcc_term_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (eng_req),
        .sts   (eng_sts)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prime_reg     <= {MOD_W{1'b1}};
            acc_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                prime_reg <= cfg.prime;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_col_reg <= out_col_next;
        out_mis_reg <= out_mis_next;
        mod_reg     <= mod_next;
        target_reg  <= target_next;
        last_reg    <= last_next;
        sum_reg     <= sum_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg && !result_out.ready;
        out_col_next   = out_col_reg;
        out_mis_next   = out_mis_reg;
        mod_next       = mod_reg;
        target_next    = target_reg;
        last_next      = last_reg;
        sum_next       = sum_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mod_next    = eng_req.modulus;
                    target_next = term_in.target_value;
                    last_next   = term_in.last_term;
                    state_next  = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (eng_sts.done)
                begin
                    sum_next   = mod_add(eng_sts.acc_residue, eng_sts.product, mod_reg);
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!last_reg)
                begin
                    acc_next   = sum_reg;
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_col_next   = col_reg;
                    out_mis_next   = (sum_reg != target_reg);
                    acc_next       = '0;
                    col_next       = col_reg + 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The engine reports completion only for a term this level is waiting on.
    a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        eng_sts.done |-> (state_reg == ST_BUSY))
        else $error("engine completion outside of a busy term");

    // A running sum that is kept is always a proper residue of the term's modulus.
    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && !last_reg) |=> (acc_reg < mod_reg))
        else $error("accumulator not reduced below modulus");

    // Closing a column publishes a result, clears the sum and advances the counter.
    a_column_close: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && last_reg && out_free) |=>
            (result_out.valid && (acc_reg == '0) && (col_reg == $past(col_reg) + 1'b1)))
        else $error("column close did not publish and advance");

    // No term is taken while a previous one is still in the engine.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !term_in.ready)
        else $error("term accepted while another is in flight");

endmodule

// ===== bench/tb_modular_column_check.sv =====
// Self-checking testbench for the modular column checker: directed corner cases and random columns.
module tb_modular_column_check
    import mcc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 600_000;
    // Long enough for any term still in the block to finish.
    localparam int unsigned SETTLE_CYCLES = 80;
    localparam int unsigned RANDOM_TERMS  = 1100;
    localparam logic [MOD_W-1:0] PRIME_AT_RESET = 31'h7FFF_FFFF;

    typedef struct {
        logic signed [VAL_W-1:0] matrix_value;
        logic [MOD_W-1:0]        coefficient;
        logic [MOD_W-1:0]        target_value;
        logic                    last_term;
    } column_term_t;

    typedef struct {
        logic [COL_W-1:0] column_index;
        logic             mismatch;
    } column_verdict_t;

    logic clk;
    logic rst_n;

    mcc_cfg_if    prime_bus();
    mcc_term_if   term_bus();
    mcc_result_if result_bus();

    modular_column_check i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (prime_bus),
        .term_in    (term_bus),
        .result_out (result_bus)
    );

    // Mirror of the block's state.
    logic [MOD_W-1:0] prime_model;
    longint unsigned  running_sum;
    logic [COL_W-1:0] column_model;
    column_verdict_t  pending_verdicts[$];

    int unsigned fail_count;
    int unsigned cycle_count;
    bit          no_gaps;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_verdicts.size());
            $display("** modular_column_check: FAILED **");
            $finish;
        end
    end

    // Sum modulo the current prime after one more term; values 0 and 1 act as modulus 1.
    function automatic longint unsigned sum_after_term(
        input longint unsigned         acc,
        input logic signed [VAL_W-1:0] entry,
        input logic [MOD_W-1:0]        coef
    );
        longint unsigned m;
        longint          entry_res;
        longint unsigned prod;
        m = (prime_model < 2) ? 64'd1 : longint'(prime_model);
        entry_res = longint'(entry) % longint'(m);
        if (entry_res < 0)
        begin
            entry_res += longint'(m);
        end
        prod = (longint'(entry_res) * longint'(coef)) % m;
        return ((acc % m) + prod) % m;
    endfunction

    function automatic void fold_term(input column_term_t t);
        column_verdict_t v;
        running_sum = sum_after_term(running_sum, t.matrix_value, t.coefficient);
        if (t.last_term)
        begin
            v.column_index = column_model;
            v.mismatch     = (running_sum != longint'(t.target_value));
            pending_verdicts = {pending_verdicts, v};
            running_sum  = 0;
            column_model = column_model + 1'b1;
        end
    endfunction

    function automatic int unsigned draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 15);
    endfunction

    // Valid is left high after acceptance so that a back-to-back request keeps it asserted without a gap.
    task automatic send_term(
        input logic signed [VAL_W-1:0] entry,
        input logic [MOD_W-1:0]        coef,
        input logic [MOD_W-1:0]        target,
        input logic                    last
    );
        column_term_t t;
        int unsigned  gap;
        t.matrix_value = entry;
        t.coefficient  = coef;
        t.target_value = target;
        t.last_term    = last;
        gap = draw_gap();
        if (gap > 0)
        begin
            term_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        term_bus.valid        <= 1'b1;
        term_bus.matrix_value <= entry;
        term_bus.coefficient  <= coef;
        term_bus.target_value <= target;
        term_bus.last_term    <= last;
        @(posedge clk);
        while (!term_bus.ready)
        begin
            @(posedge clk);
        end
        fold_term(t);
    endtask

    // Sends a term whose target equals the sum the column will reach with it.
    task automatic send_closing_term(
        input logic signed [VAL_W-1:0] entry,
        input logic [MOD_W-1:0]        coef
    );
        send_term(entry, coef, MOD_W'(sum_after_term(running_sum, entry, coef)), 1'b1);
    endtask

    task automatic wait_drained();
        term_bus.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_prime(input logic [MOD_W-1:0] value);
        wait_drained();
        prime_bus.valid <= 1'b1;
        prime_bus.prime <= value;
        @(posedge clk);
        while (!prime_bus.ready)
        begin
            @(posedge clk);
        end
        prime_bus.valid <= 1'b0;
        prime_model = value;
    endtask

    // Result side: either ready waits in advance or it is held low for a random stall after valid.
    initial
    begin
        int unsigned stall;
        result_bus.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = draw_gap();
            if (stall == 0)
            begin
                result_bus.ready <= 1'b1;
            end
            else
            begin
                result_bus.ready <= 1'b0;
                @(posedge clk);
                while (!result_bus.valid)
                begin
                    @(posedge clk);
                end
                repeat (stall) @(posedge clk);
                result_bus.ready <= 1'b1;
            end
            @(posedge clk);
            while (!(result_bus.valid && result_bus.ready))
            begin
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        column_verdict_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual column %0d mismatch %0b",
                         $time, result_bus.column_index, result_bus.mismatch);
                fail_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (result_bus.column_index !== want.column_index)
                begin
                    $display("%0t: column_index: expected %0d, actual %0d",
                             $time, want.column_index, result_bus.column_index);
                    fail_count++;
                end
                if (result_bus.mismatch !== want.mismatch)
                begin
                    $display("%0t: mismatch of column %0d: expected %0b, actual %0b",
                             $time, want.column_index, want.mismatch, result_bus.mismatch);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_field_extremes();
        send_closing_term(32'sh8000_0000, 31'h7FFF_FFFF);
        send_closing_term(32'sh7FFF_FFFF, 31'h7FFF_FFFE);
        send_term(-32'sd1, 31'h7FFF_FFFE, 31'd0, 1'b0);
        send_term(32'sd0, 31'h5555_5555, 31'd0, 1'b0);
        send_closing_term(32'sh8000_0001, 31'h2AAA_AAAA);
        send_term(32'sh1234_5678, 31'd1, 31'h7FFF_FFFE, 1'b1);
    endtask

    task automatic test_empty_column();
        send_term(32'sh0BAD_F00D, 31'd0, 31'd0, 1'b1);
        send_term(-32'sd77, 31'd0, 31'd5, 1'b1);
    endtask

    task automatic test_target_above_prime();
        send_term(32'sd3, 31'd4, 31'h7FFF_FFFF, 1'b1);
        write_prime(31'd13);
        // The sum is 7, and 20 is 7 plus the prime, so it must still miscompare.
        send_term(32'sd7, 31'd1, 31'd20, 1'b1);
        send_closing_term(-32'sd100, 31'd27);
    endtask

    task automatic test_degenerate_primes();
        write_prime(31'd0);
        send_term(32'sh7FFF_FFFF, 31'h7FFF_FFFF, 31'd0, 1'b1);
        send_term(-32'sd9, 31'd5, 31'd1, 1'b1);
        write_prime(31'd1);
        send_term(32'sh8000_0000, 31'd3, 31'd0, 1'b1);
        write_prime(31'd2);
        send_term(-32'sd3, 31'd1, 31'd0, 1'b0);
        send_closing_term(32'sd5, 31'd3);
    endtask

    task automatic test_prime_change_mid_column();
        write_prime(31'd1_000_003);
        send_term(32'sd123_456_789, 31'd777, 31'd0, 1'b0);
        send_term(-32'sd5, 31'd999_999, 31'd0, 1'b0);
        write_prime(31'd97);
        send_closing_term(32'sd1000, 31'd50);
    endtask

    task automatic send_random_column(input int unsigned len);
        logic signed [VAL_W-1:0] entry;
        logic [MOD_W-1:0]        coef;
        logic [MOD_W-1:0]        target;
        longint unsigned         m;
        m = (prime_model < 2) ? 64'd1 : longint'(prime_model);
        for (int unsigned i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 7))
                0:       entry = 32'sh8000_0000;
                1:       entry = 32'sh7FFF_FFFF;
                2:       entry = $signed(32'($urandom_range(0, 16)) - 32'd8);
                default: entry = $signed($urandom);
            endcase
            case ($urandom_range(0, 15))
                0:       coef = '0;
                1, 2:    coef = MOD_W'($urandom);
                default: coef = MOD_W'(longint'($urandom) % m);
            endcase
            if (i + 1 < len)
            begin
                send_term(entry, coef, MOD_W'($urandom), 1'b0);
            end
            else
            begin
                case ($urandom_range(0, 7))
                    0:       target = MOD_W'($urandom);
                    1, 2:    target = MOD_W'(longint'($urandom) % m);
                    default: target = MOD_W'(sum_after_term(running_sum, entry, coef));
                endcase
                send_term(entry, coef, target, 1'b1);
            end
        end
    endtask

    task automatic test_random_columns();
        logic [MOD_W-1:0] phase_primes[8];
        int unsigned      per_phase;
        int unsigned      sent;
        int unsigned      len;
        phase_primes[0] = PRIME_AT_RESET;
        phase_primes[1] = 31'd2;
        phase_primes[2] = MOD_W'($urandom_range(3, 255));
        phase_primes[3] = 31'd65521;
        phase_primes[4] = 31'd0;
        phase_primes[5] = MOD_W'($urandom_range(2, 32'h7FFF_FFFF));
        phase_primes[6] = 31'd1;
        phase_primes[7] = 31'h7FFF_FFFE;
        per_phase = RANDOM_TERMS / 8;
        foreach (phase_primes[p])
        begin
            write_prime(phase_primes[p]);
            no_gaps = (p == 3) || ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < per_phase)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
                send_random_column(len);
                sent += len;
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        fail_count   = 0;
        cycle_count  = 0;
        no_gaps      = 1'b0;
        prime_model  = PRIME_AT_RESET;
        running_sum  = 0;
        column_model = '0;
        prime_bus.valid       <= 1'b0;
        prime_bus.prime       <= '0;
        term_bus.valid        <= 1'b0;
        term_bus.matrix_value <= '0;
        term_bus.coefficient  <= '0;
        term_bus.target_value <= '0;
        term_bus.last_term    <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_empty_column();
        test_target_above_prime();
        test_degenerate_primes();
        test_prime_change_mid_column();
        test_random_columns();

        wait_drained();
        if (fail_count == 0)
        begin
            $display("** modular_column_check: PASSED **");
        end
        else
        begin
            $display("** modular_column_check: FAILED **");
        end
        $finish;
    end

endmodule
